FILE: rtl/indexed_sequence_store_defines.svh
// ============================================================================
// Assertion macros for the indexed sequence store
// Shared concurrent assertion forms; disabled when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ISS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ISS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ISS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/iss_pkg.sv
// ============================================================================
// Indexed sequence store package
// Request codes, sizes and the controller/datapath command and status types.
// ============================================================================
package iss_pkg;
   localparam int Depth   = 256;
   localparam int AddrW   = $clog2(Depth);
   localparam int CountW  = $clog2(Depth + 1);
   localparam int DataW   = 32;

   typedef enum logic [3:0] {
      REQ_APPEND   = 4'd0,
      REQ_PREPEND  = 4'd1,
      REQ_INSERT   = 4'd2,
      REQ_DEL_HEAD = 4'd3,
      REQ_DEL_TAIL = 4'd4,
      REQ_DEL_AT   = 4'd5,
      REQ_CLEAR    = 4'd6,
      REQ_READ     = 4'd7,
      REQ_WRITE    = 4'd8,
      REQ_SORT     = 4'd9
   } req_code_type;

   // memory access commands from controller to datapath
   typedef struct packed {
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [1:0]       wr_sel;     // which value to write
      logic             hold_en;    // capture read data into hold register
      logic             key_en;     // capture read data into key register
      logic             req_en;     // capture request value
   } dp_cmd_type;

   localparam logic [1:0] WSEL_REQ  = 2'd0;
   localparam logic [1:0] WSEL_RD   = 2'd1;
   localparam logic [1:0] WSEL_HOLD = 2'd2;
   localparam logic [1:0] WSEL_KEY  = 2'd3;

   typedef struct packed {
      logic [DataW-1:0] rd_data;    // registered memory read data
      logic             hold_gt_key;// signed read data > key
   } dp_sts_type;
endpackage

FILE: rtl/iss_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ============================================================================
module iss_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // storage with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/iss_datapath.sv
// ============================================================================
// Indexed sequence store datapath
// Entry memory, request value, hold and key registers, signed compare.
// ============================================================================
module iss_datapath import iss_pkg::*; (
   input  logic             clock,
   input  dp_cmd_type       cmd,
   input  logic [DataW-1:0] req_value,
   output dp_sts_type       sts
);
   logic [DataW-1:0] rd_data;
   logic [DataW-1:0] req_ff;
   logic [DataW-1:0] hold_ff;
   logic [DataW-1:0] key_ff;
   logic [DataW-1:0] wr_data;

   iss_ram #(.Width(DataW), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   // write data select
   always_comb begin
      unique case (cmd.wr_sel)
         WSEL_REQ:  wr_data = req_ff;
         WSEL_RD:   wr_data = rd_data;
         WSEL_HOLD: wr_data = hold_ff;
         default:   wr_data = key_ff;
      endcase
   end

   // work registers
   always_ff @(posedge clock) begin
      if (cmd.req_en) begin
         req_ff <= req_value;
      end
      if (cmd.hold_en) begin
         hold_ff <= rd_data;
      end
      if (cmd.key_en) begin
         key_ff <= rd_data;
      end
   end

   assign sts.rd_data     = rd_data;
   assign sts.hold_gt_key = $signed(rd_data) > $signed(key_ff);
   logic unused_hold;
   assign unused_hold = ^hold_ff;
endmodule

FILE: rtl/iss_controller.sv
// ============================================================================
// Indexed sequence store controller
// Decodes requests, sequences gap shifts, reads, writes and insertion sort.
// ============================================================================
`include "indexed_sequence_store_defines.svh"
module iss_controller import iss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_code,
   input  logic [7:0]        req_pos,
   output dp_cmd_type        cmd,
   input  dp_sts_type        sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic [DataW-1:0]  rsp_value,
   output logic [CountW-1:0] rsp_count
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_UP_RD, ST_UP_WR, ST_DN_RD, ST_DN_WR, ST_READ, ST_READ_W,
      ST_S_KEY, ST_S_KEYW, ST_S_CMP, ST_S_CMPW, ST_S_PLACE, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] idx_ff, idx_in;     // shift cursor / sort j
   logic [CountW-1:0] end_ff, end_in;     // write marker / sort i
   logic [AddrW-1:0]  tgt_ff, tgt_in;     // insert or write target
   logic              ok_ff, ok_in;
   logic [DataW-1:0]  val_ff, val_in;
   logic              in_fire;
   logic              full;
   logic [CountW-1:0] pos_ext;
   logic              pos_in_range;

   assign in_fire      = req_valid && req_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign full         = count_ff >= CountW'(Depth);
   assign pos_ext      = CountW'(req_pos);
   assign pos_in_range = pos_ext < count_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; end_in = end_ff;
      tgt_in = tgt_ff; ok_in = ok_ff; val_in = val_ff;
      cmd = '0;
      cmd.req_en = in_fire;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ok_in = 1'b0; val_in = '0;
               state_in = ST_RESP;
               unique case (req_code)
                  REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
                     if (!full && (req_code == REQ_APPEND || req_code == REQ_PREPEND
                         || pos_in_range || (pos_ext == '0 && count_ff == '0))) begin
                        ok_in  = 1'b1;
                        tgt_in = (req_code == REQ_APPEND) ? count_ff[AddrW-1:0] :
                                 (req_code == REQ_PREPEND) ? '0 : req_pos[AddrW-1:0];
                        idx_in = count_ff;
                        state_in = ST_UP_RD;
                     end
                  end
                  REQ_DEL_HEAD, REQ_DEL_AT: begin
                     if ((req_code == REQ_DEL_HEAD) ? (count_ff != '0) : pos_in_range)
                     begin
                        ok_in  = 1'b1;
                        idx_in = (req_code == REQ_DEL_HEAD) ? '0 : pos_ext;
                        state_in = ST_DN_RD;
                     end
                  end
                  REQ_DEL_TAIL: begin
                     if (count_ff != '0) begin
                        ok_in = 1'b1; count_in = count_ff - 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     ok_in = count_ff != '0; count_in = '0;
                  end
                  REQ_READ: begin
                     if (pos_in_range) begin
                        ok_in = 1'b1;
                        cmd.rd_en = 1'b1; cmd.rd_addr = req_pos[AddrW-1:0];
                        state_in = ST_READ;
                     end else begin
                        val_in = '1;
                     end
                  end
                  REQ_WRITE: begin
                     if (pos_in_range) begin
                        ok_in = 1'b1;
                        tgt_in = req_pos[AddrW-1:0];
                        state_in = ST_UP_WR;
                        idx_in = CountW'(req_pos);
                     end
                  end
                  REQ_SORT: begin
                     if (count_ff != '0) begin
                        ok_in = 1'b1; end_in = CountW'(1);
                        state_in = ST_S_KEY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // open gap: move entry idx-1 to idx until idx == tgt, then place value
         ST_UP_RD: begin
            if (idx_ff[AddrW-1:0] == tgt_ff || idx_ff == '0) begin
               cmd.wr_en = 1'b1; cmd.wr_addr = tgt_ff; cmd.wr_sel = WSEL_REQ;
               count_in = count_ff + 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_ff - 1'b1);
               state_in = ST_UP_WR;
            end
         end
         ST_UP_WR: begin
            if (end_ff == '1) begin
               // write request path
               cmd.wr_en = 1'b1; cmd.wr_addr = tgt_ff; cmd.wr_sel = WSEL_REQ;
               state_in = ST_RESP;
            end else begin
               cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[AddrW-1:0]; cmd.wr_sel = WSEL_RD;
               idx_in = idx_ff - 1'b1;
               state_in = ST_UP_RD;
            end
         end
         // close gap: move entry idx+1 to idx until idx+1 == count
         ST_DN_RD: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_ff + 1'b1);
               state_in = ST_DN_WR;
            end
         end
         ST_DN_WR: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[AddrW-1:0]; cmd.wr_sel = WSEL_RD;
            idx_in = idx_ff + 1'b1;
            state_in = ST_DN_RD;
         end
         ST_READ: state_in = ST_READ_W;
         ST_READ_W: begin
            val_in = sts.rd_data; state_in = ST_RESP;
         end
         // insertion sort: key = e[i]; j = i; shift while e[j-1] > key
         ST_S_KEY: begin
            if (end_ff >= count_ff) begin
               state_in = ST_RESP;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = end_ff[AddrW-1:0];
               idx_in = end_ff;
               state_in = ST_S_KEYW;
            end
         end
         ST_S_KEYW: begin
            cmd.key_en = 1'b1;
            state_in = ST_S_CMP;
         end
         ST_S_CMP: begin
            if (idx_ff == '0) begin
               state_in = ST_S_PLACE;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = AddrW'(idx_ff - 1'b1);
               state_in = ST_S_CMPW;
            end
         end
         ST_S_CMPW: begin
            if (sts.hold_gt_key) begin
               cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[AddrW-1:0];
               cmd.wr_sel = WSEL_RD;
               idx_in = idx_ff - 1'b1;
               state_in = ST_S_CMP;
            end else begin
               state_in = ST_S_PLACE;
            end
         end
         ST_S_PLACE: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[AddrW-1:0]; cmd.wr_sel = WSEL_KEY;
            end_in = end_ff + 1'b1;
            state_in = ST_S_KEY;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
               end_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // write request marks end as all ones so ST_UP_WR places the value
      if (state_ff == ST_IDLE && req_valid && req_code == REQ_WRITE && pos_in_range) begin
         end_in = '1;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         end_ff   <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         end_ff   <= end_in;
         ok_ff    <= ok_in;
      end
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      val_ff <= val_in;
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_ok    = ok_ff;
   assign rsp_value = val_ff;
   assign rsp_count = count_ff;

   `ISS_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CountW'(Depth))
   `ISS_ASSERT_IMP(a_ready_excl, clock, reset, rsp_valid, !req_ready)
   `ISS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ISS_ASSERT_IMP(a_wr_bound, clock, reset, cmd.wr_en, CountW'(cmd.wr_addr) <= count_ff)
endmodule

FILE: rtl/indexed_sequence_store.sv
// One request in flight; each entry move is a memory read then a write on the
// entry RAM; a response is held until it is taken, and the store stays busy.
// Reset clears count and control; entries are undefined until written.
// ============================================================================
// Indexed sequence store top level
// Ordered store of signed values with indexed insert, delete, read, write and sort.
// ============================================================================
module indexed_sequence_store import iss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [3:0] req_type, [11:4] position, [43:12] data_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [0] ok, [32:1] read_value, [41:33] entry_count
);
   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic              ok;
   logic [DataW-1:0]  value;
   logic [CountW-1:0] count;

   iss_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_code  (req_tdata[3:0]),
      .req_pos   (req_tdata[11:4]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_ok    (ok),
      .rsp_value (value),
      .rsp_count (count)
   );

   iss_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_value (req_tdata[43:12]),
      .sts       (sts)
   );

   assign rsp_tdata = {6'd0, count, value, ok};
   logic unused_in;
   assign unused_in = ^req_tdata[47:44];
endmodule

FILE: dv/tb_indexed_sequence_store.sv
`timescale 1ns / 1ps
// ============================================================================
// Indexed sequence store testbench
// Sends requests on the stream input and checks every response field against
// a predictor that keeps its own copy of the sequence or a typed row's fields.
// A directed table comes first, then fill-to-full, then random traffic with stalls.
// ============================================================================
module tb_indexed_sequence_store import iss_pkg::*;;

   localparam logic [3:0] REQ_UNUSED_HI = 4'hF;

   typedef struct {
      logic        [3:0]  code;
      logic        [7:0]  pos;
      logic signed [31:0] val;
      bit                 typed;
      logic               ok;
      logic signed [31:0] rd;
      logic        [8:0]  cnt;
   } dir_row_type;

   typedef struct {
      logic               ok;
      logic signed [31:0] rd;
      logic        [8:0]  cnt;
   } rsp_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [3:0] req_type, [11:4] position, [43:12] data_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [0] ok, [32:1] read_value, [41:33] entry_count

   // predictor state
   logic signed [31:0] seq_vals [0:Depth-1];
   int                 seq_cnt = 0;
   rsp_fields_type     pending_rsp [$];

   // request being offered and its typed expectation, if any
   bit                 cur_typed = 1'b0;
   rsp_fields_type     cur_fixed;
   logic               req_fire = 1'b0;
   bit                 noise_on = 1'b1;
   int                 errors = 0;
   int                 rsp_seen = 0;
   int                 req_sent = 0;
   int                 sorts_ok = 0;
   int                 full_hits = 0;

   dir_row_type dir_tab [24];

   indexed_sequence_store dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d responses outstanding", pending_rsp.size());
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // apply one request to the predictor state and return its response
   function automatic rsp_fields_type apply_request(input logic [3:0] code,
                                                    input logic [7:0] pos,
                                                    input logic signed [31:0] val);
      rsp_fields_type     r;
      int                 i;
      int                 j;
      logic signed [31:0] v;
      bit                 full;
      r.ok = 1'b0;
      r.rd = '0;
      full = seq_cnt >= Depth;
      case (code)
         REQ_APPEND: if (!full) begin
            seq_vals[seq_cnt] = val;
            seq_cnt++;
            r.ok = 1'b1;
         end
         REQ_PREPEND, REQ_INSERT: begin
            j = (code == REQ_PREPEND) ? 0 : int'(pos);
            if (!full && (j < seq_cnt || (j == 0 && seq_cnt == 0))) begin
               for (i = seq_cnt; i > j; i--) seq_vals[i] = seq_vals[i-1];
               seq_vals[j] = val;
               seq_cnt++;
               r.ok = 1'b1;
            end
         end
         REQ_DEL_HEAD, REQ_DEL_AT: begin
            j = (code == REQ_DEL_HEAD) ? 0 : int'(pos);
            if (j < seq_cnt) begin
               for (i = j; i + 1 < seq_cnt; i++) seq_vals[i] = seq_vals[i+1];
               seq_cnt--;
               r.ok = 1'b1;
            end
         end
         REQ_DEL_TAIL: if (seq_cnt > 0) begin
            seq_cnt--;
            r.ok = 1'b1;
         end
         REQ_CLEAR: begin
            r.ok = seq_cnt != 0;
            seq_cnt = 0;
         end
         REQ_READ: if (pos < seq_cnt) begin
            r.rd = seq_vals[pos];
            r.ok = 1'b1;
         end else begin
            r.rd = -1;
         end
         REQ_WRITE: if (pos < seq_cnt) begin
            seq_vals[pos] = val;
            r.ok = 1'b1;
         end
         REQ_SORT: if (seq_cnt > 0) begin
            // stable insertion sort, signed ascending
            for (i = 1; i < seq_cnt; i++) begin
               v = seq_vals[i];
               j = i;
               while (j > 0 && seq_vals[j-1] > v) begin
                  seq_vals[j] = seq_vals[j-1];
                  j--;
               end
               seq_vals[j] = v;
            end
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.cnt = seq_cnt[8:0];
      return r;
   endfunction

   // request acceptance: predict and queue the response
   always @(posedge clock) begin
      rsp_fields_type p;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         p = apply_request(req_tdata[3:0], req_tdata[11:4], req_tdata[43:12]);
         if (req_tdata[3:0] == REQ_SORT && p.ok) sorts_ok++;
         if (seq_cnt == Depth) full_hits++;
         pending_rsp.push_back(cur_typed ? cur_fixed : p);
      end
   end

   // response check
   always @(posedge clock) begin
      rsp_fields_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected", $realtime);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tdata[0] !== e.ok) report_mismatch("ok", rsp_tdata[0], e.ok);
            if (rsp_tdata[32:1] !== e.rd) report_mismatch("read_value", rsp_tdata[32:1], e.rd);
            if (rsp_tdata[41:33] !== e.cnt)
               report_mismatch("entry_count", rsp_tdata[41:33], e.cnt);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= noise_on ? ($urandom_range(99) >= 20) : 1'b1;
   end

   task automatic send_request(input logic [3:0] code, input logic [7:0] pos,
                               input logic signed [31:0] val, input bit typed,
                               input rsp_fields_type fixed);
      while (noise_on && $urandom_range(99) < 20) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {4'b0, val, pos, code};
      cur_typed  = typed;
      cur_fixed  = fixed;
      req_tvalid = 1'b1;
      do @(negedge clock); while (!req_fire);
      req_sent++;
   endtask

   task automatic send_plain(input logic [3:0] code, input logic [7:0] pos,
                             input logic signed [31:0] val);
      rsp_fields_type none;
      none = '{1'b0, '0, '0};
      send_request(code, pos, val, 1'b0, none);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return -1;
         3: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int             i;
      int             r;
      logic [3:0]     code;
      logic [7:0]     pos;
      rsp_fields_type fx;

      dir_tab = '{
         '{REQ_READ,      8'd0,   0,            1, 1'b0, -1,           9'd0},
         '{REQ_DEL_HEAD,  8'd0,   0,            1, 1'b0, 0,            9'd0},
         '{REQ_DEL_TAIL,  8'd0,   0,            1, 1'b0, 0,            9'd0},
         '{REQ_DEL_AT,    8'd0,   0,            1, 1'b0, 0,            9'd0},
         '{REQ_CLEAR,     8'd0,   0,            1, 1'b0, 0,            9'd0},
         '{REQ_SORT,      8'd0,   0,            1, 1'b0, 0,            9'd0},
         '{REQ_WRITE,     8'd0,   5,            1, 1'b0, 0,            9'd0},
         '{REQ_INSERT,    8'd1,   9,            1, 1'b0, 0,            9'd0},
         '{REQ_INSERT,    8'd0,   42,           1, 1'b1, 0,            9'd1},
         // deleting the only entry
         '{REQ_DEL_HEAD,  8'd0,   0,            1, 1'b1, 0,            9'd0},
         '{REQ_INSERT,    8'd0,   42,           1, 1'b1, 0,            9'd1},
         '{REQ_APPEND,    8'd0,   32'h7FFFFFFF, 0, 1'b0, 0,            9'd0},
         '{REQ_PREPEND,   8'd0,   32'h80000000, 0, 1'b0, 0,            9'd0},
         // insert before the last entry
         '{REQ_INSERT,    8'd2,   0,            0, 1'b0, 0,            9'd0},
         '{REQ_READ,      8'd0,   0,            1, 1'b1, 32'h80000000, 9'd4},
         '{REQ_READ,      8'd255, 0,            1, 1'b0, -1,           9'd4},
         '{REQ_WRITE,     8'd3,   -1,           0, 1'b0, 0,            9'd0},
         '{REQ_SORT,      8'd0,   0,            0, 1'b0, 0,            9'd0},
         '{REQ_READ,      8'd1,   0,            0, 1'b0, 0,            9'd0},
         '{REQ_DEL_AT,    8'd1,   0,            0, 1'b0, 0,            9'd0},
         '{REQ_DEL_AT,    8'd255, 0,            0, 1'b0, 0,            9'd0},
         '{REQ_UNUSED_HI, 8'd255, -1,           0, 1'b0, 0,            9'd0},
         '{REQ_DEL_TAIL,  8'd0,   0,            0, 1'b0, 0,            9'd0},
         '{REQ_CLEAR,     8'd0,   0,            1, 1'b1, 0,            9'd0}
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[k]) begin
         fx = '{dir_tab[k].ok, dir_tab[k].rd, dir_tab[k].cnt};
         send_request(dir_tab[k].code, dir_tab[k].pos, dir_tab[k].val, dir_tab[k].typed, fx);
      end

      // fill to full with ascending values, push on the full store, then sort, read, write, delete, insert and clear
      for (i = 0; i < Depth; i++) send_plain(REQ_APPEND, 8'd0, i * 1000 - 128000);
      send_plain(REQ_APPEND, 8'd0, 1);
      send_plain(REQ_PREPEND, 8'd0, 2);
      send_plain(REQ_INSERT, 8'd5, 3);
      send_plain(REQ_SORT, 8'd0, 0);
      send_plain(REQ_READ, 8'd255, 0);
      send_plain(REQ_WRITE, 8'd255, 32'h7FFFFFFF);
      send_plain(REQ_DEL_AT, 8'd0, 0);
      send_plain(REQ_INSERT, 8'd254, 32'h80000000);
      send_plain(REQ_READ, 8'd254, 0);
      send_plain(REQ_CLEAR, 8'd0, 0);

      // random traffic, sequence kept short so sorts and shifts stay cheap
      for (i = 0; i < 260; i++) begin
         noise_on = !(i >= 100 && i < 160);
         if (i == 200) begin
            req_tvalid = 1'b0;
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         r = $urandom_range(99);
         if      (r < 15) code = REQ_APPEND;
         else if (r < 25) code = REQ_PREPEND;
         else if (r < 40) code = REQ_INSERT;
         else if (r < 47) code = REQ_DEL_HEAD;
         else if (r < 54) code = REQ_DEL_TAIL;
         else if (r < 66) code = REQ_DEL_AT;
         else if (r < 68) code = REQ_CLEAR;
         else if (r < 82) code = REQ_READ;
         else if (r < 94) code = REQ_WRITE;
         else if (r < 97) code = REQ_SORT;
         else             code = 4'($urandom_range(10, 15));
         if (seq_cnt > 48 && (code == REQ_APPEND || code == REQ_PREPEND || code == REQ_INSERT))
            code = REQ_DEL_AT;
         if ($urandom_range(99) < 85) pos = 8'($urandom_range(0, seq_cnt > 255 ? 255 : seq_cnt));
         else                         pos = 8'($urandom_range(0, 255));
         send_plain(code, pos, pick_value());
      end
      req_tvalid = 1'b0;
      noise_on   = 1'b0;

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("sent %0d requests, checked %0d responses, %0d sorts, store full %0d times",
               req_sent, rsp_seen, sorts_ok, full_hits);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d errors, %0d responses missing", errors, pending_rsp.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule
